/* hdl/assert_macros.svh */
// Assertion helpers for the RTL, included by track_sector_framer.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tsf_pkg.sv */
package tsf_pkg;

    // Field and state widths.
    localparam int POS_W   = 14;
    localparam int SUM_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int PHASE_W = 3;

    // Track layout.
    localparam int SECTOR_BYTES = 2558;
    localparam int GAP_BYTES    = 448;
    localparam int FILL_MIN     = 'hDF;

    localparam logic [POS_W-1:0] GAP_END    = POS_W'(GAP_BYTES);
    localparam logic [POS_W-1:0] DATA_END   = POS_W'(GAP_BYTES + 1 + SECTOR_BYTES);
    localparam logic [POS_W-1:0] MIN_LEN    = POS_W'(SECTOR_BYTES + 2 + FILL_MIN);
    localparam logic [POS_W-1:0] LEN_RESET  = POS_W'(6250);

    localparam logic [BYTE_W-1:0] GAP_VALUE  = 8'h00;
    localparam logic [BYTE_W-1:0] SYNC_VALUE = 8'hFF;

    // Phase codes.
    localparam logic [PHASE_W-1:0] PHASE_GAP  = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_SYNC = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_DATA = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_CSUM = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_FILL = 3'd4;

    // Swap bit 0 with bit 7, bit 1 with bit 6, and so on.
    function automatic logic [BYTE_W-1:0] reverse8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int b = 0; b < BYTE_W; b++) begin
            r[b] = v[BYTE_W-1-b];
        end
        return r;
    endfunction

endpackage

/* hdl/track_sector_framer.sv */
// Channel   Direction  Transaction
// s_*       in         one request for the next track byte (data byte, restart)
// m_*       out        one track byte with its phase and flags
// cfg_*     in         write of the track length, no handshake
//
// Each input transaction yields exactly one output transaction, registered and valid in the following cycle.
// A new transaction is accepted every cycle; the one-deep output register sets
// the rate, so throughput is one byte per cycle while m_tready stays high.
// When the output register is full and m_tready is low, s_tready drops.
// Reset (aresetn low, synchronous) clears position, checksum, the output valid
// and loads the track length with 6250.
`include "assert_macros.svh"

module track_sector_framer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration
    input  logic                          cfg_wr_en,
    input  logic [tsf_pkg::POS_W-1:0]     cfg_wr_data,   // track_length
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,       // [7:0] data_byte
    input  logic [0:0]                    s_tuser,       // [0] restart
    // Output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,       // [7:0] track_byte
    output logic [4:0]                    m_tuser,       // [0] data_taken, [3:1] phase,
                                                         // [4] too_short
    output logic                          m_tlast        // last
);
    import tsf_pkg::*;

    logic [POS_W-1:0]   track_len_reg;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               m_valid_reg;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic               taken_reg, taken_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               last_reg, last_next;
    logic               short_reg, short_next;

    logic               s_fire;
    logic [POS_W-1:0]   pos_base;
    logic [SUM_W-1:0]   sum_base;
    logic [POS_W:0]     pos_inc;
    logic [BYTE_W-1:0]  raw_byte;

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = !m_valid_reg || m_tready;

    // Next track byte and state update for the accepted transaction.
    always_comb begin
        pos_base   = s_tuser[0] ? '0 : pos_reg;
        sum_base   = s_tuser[0] ? '0 : sum_reg;
        pos_inc    = {1'b0, pos_base} + (POS_W+1)'(1);
        raw_byte   = GAP_VALUE;
        taken_next = 1'b0;
        phase_next = PHASE_GAP;
        last_next  = 1'b0;
        short_next = 1'b0;
        pos_next   = pos_base;
        sum_next   = sum_base;

        if (track_len_reg < MIN_LEN) begin
            // Track cannot hold the sector: report and keep the state, which only a restart clears.
            short_next = 1'b1;
        end else begin
            if (pos_base < GAP_END) begin
                raw_byte   = GAP_VALUE;
                phase_next = PHASE_GAP;
            end else if (pos_base == GAP_END) begin
                raw_byte   = SYNC_VALUE;
                phase_next = PHASE_SYNC;
            end else if (pos_base < DATA_END) begin
                sum_next   = sum_base + SUM_W'(s_tdata);
                raw_byte   = s_tdata;
                taken_next = 1'b1;
                phase_next = PHASE_DATA;
            end else if (pos_base == DATA_END) begin
                raw_byte   = sum_base[BYTE_W-1:0];
                phase_next = PHASE_CSUM;
            end else if (pos_base == DATA_END + POS_W'(1)) begin
                raw_byte   = sum_base[SUM_W-1:BYTE_W];
                phase_next = PHASE_CSUM;
            end else begin
                raw_byte   = sum_base[SUM_W-1:BYTE_W];
                phase_next = PHASE_FILL;
            end

            // End of track wraps position and checksum.
            if (pos_inc >= {1'b0, track_len_reg}) begin
                last_next = 1'b1;
                pos_next  = '0;
                sum_next  = '0;
            end else begin
                pos_next  = pos_inc[POS_W-1:0];
            end
        end

        byte_next = short_next ? '0 : reverse8(raw_byte);
    end

    // Configuration register and framing state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_len_reg <= LEN_RESET;
            pos_reg       <= '0;
            sum_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                track_len_reg <= cfg_wr_data;
            end
            if (s_fire) begin
                pos_reg <= pos_next;
                sum_reg <= sum_next;
            end
        end
    end

    // Output register valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            byte_reg  <= byte_next;
            taken_reg <= taken_next;
            phase_reg <= phase_next;
            last_reg  <= last_next;
            short_reg <= short_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = {short_reg, phase_reg, taken_reg};
    assign m_tlast  = last_reg;

    // Checks on the framing logic.
    `ASSERT_IMPLIES(a_short_clean, aclk, aresetn, m_valid_reg && short_reg,
                    byte_reg == '0 && !last_reg && !taken_reg && phase_reg == PHASE_GAP,
                    "too_short result carries payload")
    `ASSERT_IMPLIES(a_taken_data, aclk, aresetn, m_valid_reg && taken_reg,
                    phase_reg == PHASE_DATA, "data taken outside the data phase")
    `ASSERT_NEXT(a_wrap_clear, aclk, aresetn, s_fire && last_next,
                 pos_reg == '0 && sum_reg == '0, "state not cleared after the last byte")
    `ASSERT_IMPLIES(a_ready_empty, aclk, aresetn, !m_valid_reg, s_tready,
                    "input stalled with empty output register")

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import tsf_pkg::*;

    localparam int          HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 500_000;

    // One predicted or observed track byte with its flags.
    typedef struct packed {
        logic [BYTE_W-1:0]  track_byte;
        logic               data_taken;
        logic [PHASE_W-1:0] phase;
        logic               last;
        logic               too_short;
    } track_result_t;

    // Tracks the framer state and holds the track bytes still owed by the block.
    class track_scoreboard;
        logic [POS_W-1:0] length_q;
        logic [POS_W-1:0] pos_q;
        logic [SUM_W-1:0] csum_q;
        track_result_t    owed_q[$];
        int               failures;
        int               bytes_seen;
        int               tracks_seen;
        int               sector_bytes_seen;
        int               too_short_seen;

        function new();
            length_q          = LEN_RESET;
            pos_q             = '0;
            csum_q            = '0;
            failures          = 0;
            bytes_seen        = 0;
            tracks_seen       = 0;
            sector_bytes_seen = 0;
            too_short_seen    = 0;
        endfunction

        function void set_length(logic [POS_W-1:0] v);
            length_q = v;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10) begin
                $display("ERROR at %0t: %s", $realtime, msg);
            end
        endfunction

        // Works out the next track byte and advances position and checksum.
        function track_result_t next_byte(logic [BYTE_W-1:0] d, logic rs);
            track_result_t     t;
            int                p;
            logic [BYTE_W-1:0] b;
            t = '0;
            b = GAP_VALUE;
            if (rs) begin
                pos_q  = '0;
                csum_q = '0;
            end
            if (length_q < MIN_LEN) begin
                t.too_short = 1'b1;
                return t;
            end
            p = int'(pos_q);
            if (p < GAP_BYTES) begin
                t.phase = PHASE_GAP;
            end else if (p == GAP_BYTES) begin
                b       = SYNC_VALUE;
                t.phase = PHASE_SYNC;
            end else if (p < DATA_END) begin
                csum_q       = csum_q + d;
                b            = d;
                t.data_taken = 1'b1;
                t.phase      = PHASE_DATA;
            end else if (p == DATA_END) begin
                b       = csum_q[7:0];
                t.phase = PHASE_CSUM;
            end else if (p == DATA_END + 1) begin
                b       = csum_q[15:8];
                t.phase = PHASE_CSUM;
            end else begin
                b       = csum_q[15:8];
                t.phase = PHASE_FILL;
            end
            // The track wraps on the byte at or past the configured length.
            if (p + 1 >= length_q) begin
                t.last = 1'b1;
                pos_q  = '0;
                csum_q = '0;
            end else begin
                pos_q = POS_W'(p + 1);
            end
            t.track_byte = {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
            return t;
        endfunction

        function void note_request(logic [BYTE_W-1:0] d, logic rs);
            owed_q.push_back(next_byte(d, rs));
        endfunction

        function void check_byte(logic [7:0] tdata, logic [4:0] tuser, logic tlast);
            track_result_t got;
            track_result_t want;
            got.track_byte = tdata;
            got.data_taken = tuser[0];
            got.phase      = tuser[3:1];
            got.too_short  = tuser[4];
            got.last       = tlast;
            bytes_seen++;
            if (owed_q.size() == 0) begin
                flag($sformatf("track byte %02h arrived with nothing outstanding", tdata));
                return;
            end
            want = owed_q.pop_front();
            if (want.last) tracks_seen++;
            if (want.data_taken) sector_bytes_seen++;
            if (want.too_short) too_short_seen++;
            if (got !== want) begin
                flag($sformatf({"mismatch (expected/actual): track_byte %02h/%02h ",
                                "data_taken %0b/%0b phase %0d/%0d last %0b/%0b ",
                                "too_short %0b/%0b"},
                               want.track_byte, got.track_byte,
                               want.data_taken, got.data_taken,
                               want.phase, got.phase, want.last, got.last,
                               want.too_short, got.too_short));
            end
        endfunction
    endclass

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [POS_W-1:0]    cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata     = '0;
    logic [0:0]          s_tuser     = '0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [7:0]          m_tdata;
    logic [4:0]          m_tuser;
    logic                m_tlast;

    track_scoreboard sb;
    bit              quiet        = 1'b0;
    bit              hold_off_req = 1'b0;
    int              hold_offs    = 0;
    int unsigned     cycle_count  = 0;

    track_sector_framer u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #10 aclk = ~aclk;

    // Abort a run that hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles without finishing.", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Record every request transaction and check every track byte transaction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_request(s_tdata, s_tuser[0]);
            if (m_tvalid && m_tready) sb.check_byte(m_tdata, m_tuser, m_tlast);
        end
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(16, 40);
    endfunction

    // Sector data leaning on the all-zeros and all-ones bytes.
    function automatic logic [7:0] pick_data();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : result_sink
        int n;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
                hold_offs++;
            end else begin
                n = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    // Offer one request and return at the edge where it is accepted.
    task automatic send_request(input logic [7:0] d, input logic rs);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= d;
        s_tuser[0] <= rs;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_run(input int count, input int restart_odds, input bit restart_first);
        logic rs;
        for (int i = 0; i < count; i++) begin
            rs = (restart_first && i == 0) ||
                 (restart_odds > 0 && $urandom_range(1, restart_odds) == 1);
            send_request(pick_data(), rs);
        end
    endtask

    // Stop offering and wait until every owed track byte has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_track_length(input logic [POS_W-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_length(v);
    endtask

    initial begin : stimulus
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset length, restarts, data extremes, too-short lengths, the largest length.
        send_request(8'h00, 1'b1);
        send_request(8'hFF, 1'b0);
        send_request(8'h01, 1'b0);
        send_request(8'h80, 1'b0);
        send_request(8'hAA, 1'b0);
        send_request(8'h55, 1'b1);
        set_track_length('0);
        send_request(8'hFF, 1'b0);
        send_request(8'h00, 1'b1);
        send_request(8'h5A, 1'b0);
        set_track_length(MIN_LEN - POS_W'(1));
        send_request(8'hA5, 1'b0);
        send_request(8'h3C, 1'b1);
        set_track_length({POS_W{1'b1}});
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);

        // Gap, sync and the start of the data under a long result hold-off.
        set_track_length(LEN_RESET);
        hold_off_req = 1'b1;
        send_run(500, 0, 1'b1);

        // A too-short length mid-track leaves position and checksum alone.
        set_track_length(MIN_LEN - POS_W'(1));
        send_run(20, 0, 1'b0);

        // Back to a legal length, continuing the same track at full rate.
        set_track_length(MIN_LEN);
        quiet = 1'b1;
        send_run(300, 0, 1'b0);
        quiet = 1'b0;

        // Noise: frequent restarts, then too-short lengths with restarts.
        set_track_length(POS_W'($urandom_range(MIN_LEN, 16383)));
        send_run(150, 16, 1'b0);
        set_track_length(POS_W'($urandom_range(0, MIN_LEN - 1)));
        send_run(60, 4, 1'b0);

        drain();
        $display("Checked %0d track bytes: %0d tracks, %0d sector bytes, %0d too short.",
                 sb.bytes_seen, sb.tracks_seen, sb.sector_bytes_seen, sb.too_short_seen);
        $display("Gap, sync and data phases, short lengths and restarts, %0d hold-off.",
                 hold_offs);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d failures, %0d track bytes still owed.", sb.failures, sb.pending());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/tsf_pkg.sv
hdl/track_sector_framer.sv
tb/tb.sv
